FILE: rtl/core/lgd_pkg.sv
package lgd_pkg;

    localparam int LGD_SITE_W   = 24;
    localparam int LGD_FRAC_W   = 16;
    localparam int LGD_THR_W    = 17;
    // neighbour index width that covers the largest lattice side
    localparam int LGD_NBR_W    = 26;
    localparam int LGD_CFG_IDX_W = 2;
    localparam int LGD_Q_DEPTH  = 4;
    localparam int LGD_Q_PTR_W  = $clog2(LGD_Q_DEPTH);

    localparam logic [LGD_THR_W-1:0] LGD_DECAY_RESET  = 17'd24707;
    localparam logic [LGD_THR_W-1:0] LGD_GROWTH_RESET = 17'd65536;

    localparam int LGD_IN_DATA_W  = 48;
    localparam int LGD_IN_USER_W  = 2;
    localparam int LGD_OUT_DATA_W = 56;

    // output bit positions
    localparam int LGD_O_OCC_BIT = 24;
    localparam int LGD_O_CHG_BIT = 25;
    localparam int LGD_O_NBR_LSB = 26;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_READ   = 2'd2
    } t_act;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [LGD_CFG_IDX_W-1:0] {
        CFG_DECAY  = 2'd0,
        CFG_GROWTH = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SITE,
        BK_NBR
    } t_bstate;

    typedef struct packed {
        t_act                  kind;
        logic                  in_range;
        logic [LGD_SITE_W-1:0] site;
        logic                  load_value;
        logic [LGD_FRAC_W-1:0] frac;
        logic [LGD_NBR_W-1:0]  nbr;
    } t_job;

    typedef struct packed {
        logic [LGD_SITE_W-1:0] neighbour_site;
        logic                  changed;
        logic                  occupied;
        logic [LGD_SITE_W-1:0] out_site;
    } t_result;

    typedef struct packed {
        logic [LGD_THR_W-1:0] decay;
        logic [LGD_THR_W-1:0] growth;
    } t_thresh;

endpackage

FILE: rtl/core/lgd_front.sv
module lgd_front
    import lgd_pkg::*;
#(
    parameter int SIDE = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [LGD_IN_USER_W-1:0]  i_action,
    input  logic [LGD_SITE_W-1:0]     i_site,
    input  logic                      i_load_value,
    input  logic [1:0]                i_direction,
    input  logic [LGD_FRAC_W-1:0]     i_frac,
    output logic                      o_push,
    input  logic                      i_full,
    output t_job                      o_job
);

    localparam int SIDE_L = $clog2(SIDE);
    localparam int SH = LGD_SITE_W + SIDE_L;
    localparam int RECIP_W = LGD_SITE_W + 2;
    localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(SIDE) - 64'd1) / 64'(SIDE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
    localparam int PROD_W = LGD_SITE_W + RECIP_W;
    localparam int QS_W = LGD_SITE_W + SIDE_L + 1;
    localparam logic [63:0] CELLS = 64'(SIDE) * 64'(SIDE);
    localparam int NW = LGD_NBR_W + 1;
    localparam logic [NW-1:0] N_SIDE   = NW'(SIDE);
    localparam logic [NW-1:0] N_SIDE_M = NW'(SIDE - 1);
    localparam logic [NW-1:0] N_WRAP   = NW'(CELLS - 64'(SIDE));

    // stage 1: row estimate by reciprocal product
    logic                     r1_v;
    t_act                     r1_kind;
    logic [LGD_SITE_W-1:0]    r1_site;
    logic                     r1_load;
    t_dir                     r1_dir;
    logic [LGD_FRAC_W-1:0]    r1_frac;
    logic [PROD_W-1:0]        r1_prod;

    logic                     r2_v;
    t_job                     r2_job;

    logic                     en;
    t_act                     kind;
    logic [LGD_SITE_W-1:0]    row;
    logic [QS_W-1:0]          row_base;
    logic [QS_W-1:0]          site_q;
    logic                     col_first;
    logic                     col_last;
    logic                     row_first;
    logic                     row_last;
    logic [NW-1:0]            site_n;
    logic [NW-1:0]            nbr;
    t_job                     n_job;

    assign en      = !r2_v || !i_full;
    assign o_ready = en;
    assign o_push  = r2_v && !i_full;
    assign o_job   = r2_job;

    always_comb begin
        case (t_act'(i_action))
            ACT_LOAD:   kind = ACT_LOAD;
            ACT_UPDATE: kind = ACT_UPDATE;
            default:    kind = ACT_READ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
        if (en) begin
            r1_kind <= kind;
            r1_site <= i_site;
            r1_load <= i_load_value;
            r1_dir  <= t_dir'(i_direction);
            r1_frac <= i_frac;
            r1_prod <= PROD_W'(i_site) * PROD_W'(RECIP);
        end
    end

    // stage 2: column edges and wrapped neighbour
    always_comb begin
        row       = LGD_SITE_W'(r1_prod >> SH);
        row_base  = QS_W'(row) * QS_W'(SIDE);
        site_q    = QS_W'(r1_site);
        col_first = (site_q == row_base);
        col_last  = (site_q == row_base + QS_W'(SIDE - 1));
        site_n    = NW'(r1_site);
        row_first = (site_n < N_SIDE);
        row_last  = (site_n >= N_WRAP);
        case (r1_dir)
            DIR_LEFT:  nbr = col_first ? site_n + N_SIDE_M : site_n - NW'(1);
            DIR_RIGHT: nbr = col_last  ? site_n - N_SIDE_M : site_n + NW'(1);
            DIR_UP:    nbr = row_first ? site_n + N_WRAP   : site_n - N_SIDE;
            DIR_DOWN:  nbr = row_last  ? site_n - N_WRAP   : site_n + N_SIDE;
            default:   nbr = '0;
        endcase
        n_job.kind       = r1_kind;
        n_job.in_range   = (64'(r1_site) < CELLS);
        n_job.site       = r1_site;
        n_job.load_value = r1_load;
        n_job.frac       = r1_frac;
        n_job.nbr        = nbr[LGD_NBR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_job <= n_job;
        end
    end

endmodule

FILE: rtl/core/lgd_queue.sv
module lgd_queue
    import lgd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job                 r_mem [LGD_Q_DEPTH];
    logic [LGD_Q_PTR_W-1:0] r_wr;
    logic [LGD_Q_PTR_W-1:0] r_rd;
    logic [LGD_Q_PTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (LGD_Q_PTR_W+1)'(LGD_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: rtl/core/lgd_back.sv
module lgd_back
    import lgd_pkg::*;
#(
    parameter int SIDE = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_thresh i_thr,
    input  logic    i_empty,
    input  t_job    i_head,
    output logic    o_pop,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    output t_result o_res
);

    localparam logic [63:0] CELLS = 64'(SIDE) * 64'(SIDE);
    localparam int ADDR_W = $clog2(CELLS);

    logic                  r_mem [CELLS];
    logic                  r_rdata;
    t_bstate               r_state;
    t_bstate               n_state;
    t_job                  r_job;
    logic                  r_ovalid;
    t_result               r_res;

    logic                  slot_free;
    logic                  head_lookup;
    logic                  decay_hit;
    logic                  growth_hit;
    logic                  mem_we;
    logic                  mem_re;
    logic                  mem_wd;
    logic [ADDR_W-1:0]     mem_addr;
    logic [ADDR_W-1:0]     head_addr;
    logic [ADDR_W-1:0]     job_addr;
    logic [LGD_NBR_W-1:0]  head_ext;
    logic [LGD_NBR_W-1:0]  job_ext;
    logic                  emit;
    t_result               emit_res;

    assign slot_free   = !r_ovalid || i_m_ready;
    assign head_lookup = !i_empty && (i_head.kind != ACT_LOAD) && i_head.in_range;
    assign decay_hit   = ({1'b0, r_job.frac} < i_thr.decay);
    assign growth_hit  = r_rdata && ({1'b0, r_job.frac} < i_thr.growth);
    assign head_ext    = LGD_NBR_W'(i_head.site);
    assign job_ext     = LGD_NBR_W'(r_job.site);
    assign head_addr   = head_ext[ADDR_W-1:0];
    assign job_addr    = job_ext[ADDR_W-1:0];
    assign o_m_valid   = r_ovalid;
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (head_lookup) begin
                    n_state = BK_SITE;
                end
            end
            BK_SITE: begin
                if (r_job.kind == ACT_UPDATE && !r_rdata) begin
                    n_state = BK_NBR;
                end else if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            BK_NBR: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_wd   = 1'b0;
        mem_addr = job_addr;
        o_pop    = 1'b0;
        emit     = 1'b0;
        emit_res = '0;
        case (r_state)
            BK_IDLE: begin
                mem_addr          = head_addr;
                emit_res.out_site = i_head.site;
                if (head_lookup) begin
                    o_pop  = 1'b1;
                    mem_re = 1'b1;
                end else if (!i_empty && slot_free) begin
                    // load, or a lookup outside the lattice
                    o_pop = 1'b1;
                    emit  = 1'b1;
                    if (i_head.kind == ACT_LOAD && i_head.in_range) begin
                        mem_we            = 1'b1;
                        mem_wd            = i_head.load_value;
                        emit_res.occupied = i_head.load_value;
                    end
                end
            end
            BK_SITE: begin
                emit_res.out_site = r_job.site;
                if (r_job.kind == ACT_UPDATE && !r_rdata) begin
                    mem_re   = 1'b1;
                    mem_addr = r_job.nbr[ADDR_W-1:0];
                end else if (slot_free) begin
                    emit              = 1'b1;
                    emit_res.occupied = r_rdata;
                    if (r_job.kind == ACT_UPDATE && decay_hit) begin
                        mem_we            = 1'b1;
                        emit_res.occupied = 1'b0;
                        emit_res.changed  = 1'b1;
                    end
                end
            end
            BK_NBR: begin
                emit_res.out_site       = r_job.site;
                emit_res.neighbour_site = r_job.nbr[LGD_SITE_W-1:0];
                if (slot_free) begin
                    emit              = 1'b1;
                    emit_res.occupied = growth_hit;
                    emit_res.changed  = growth_hit;
                    mem_we            = growth_hit;
                    mem_wd            = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_job <= i_head;
        end
        if (emit) begin
            r_res <= emit_res;
        end
    end

    // single-port lattice store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

endmodule

FILE: rtl/core/lattice_growth_decay_update_top.sv
// Lattice growth/decay update on a SIDE x SIDE periodic lattice of one-bit sites, one result
// item per input item, in input order. The lattice unit ends a load in its idle state, a read
// or occupied-site update in the site-read state and an empty-site update in the
// neighbour-read state after that, set by the single-port memory's registered read. The input
// side runs a 2-stage pipeline that works out the wrapped neighbour and feeds a 4-item queue,
// so it keeps accepting while the lattice unit or the output is busy until the queue is full.
// The lattice memory is not cleared: every site must be loaded before it is read or updated.
// Thresholds are 17-bit fixed point where 65536 means always; the decay threshold resets to
// 24707 and the growth threshold to 65536. Write thresholds only while no item is in flight.
module lattice_growth_decay_update_top
    import lgd_pkg::*;
#(
    parameter int SIDE = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // site[23:0], load_value[24], direction[26:25], random_fraction[42:27], zero fill
    input  logic [LGD_IN_DATA_W-1:0]   i_s_axis_tdata,
    // action[1:0]
    input  logic [LGD_IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // out_site[23:0], occupied[24], changed[25], neighbour_site[49:26], zero fill
    output logic [LGD_OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [LGD_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [LGD_THR_W-1:0]       i_cfg_data
);

    t_thresh r_thr;
    logic    push;
    logic    full;
    logic    pop;
    logic    empty;
    t_job    job_in;
    t_job    head;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.decay  <= LGD_DECAY_RESET;
            r_thr.growth <= LGD_GROWTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DECAY) begin
                r_thr.decay <= i_cfg_data;
            end else if (i_cfg_index == CFG_GROWTH) begin
                r_thr.growth <= i_cfg_data;
            end
        end
    end

    lgd_front #(
        .SIDE (SIDE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_action     (i_s_axis_tuser),
        .i_site       (i_s_axis_tdata[23:0]),
        .i_load_value (i_s_axis_tdata[24]),
        .i_direction  (i_s_axis_tdata[26:25]),
        .i_frac       (i_s_axis_tdata[42:27]),
        .o_push       (push),
        .i_full       (full),
        .o_job        (job_in)
    );

    lgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    lgd_back #(
        .SIDE (SIDE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_thr     (r_thr),
        .i_empty   (empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_res     (res)
    );

    assign o_m_axis_tdata = {6'd0, res.neighbour_site, res.changed, res.occupied, res.out_site};

endmodule

FILE: rtl/core/lgd_monitor.sv
module lgd_monitor
    import lgd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_m_valid,
    input  logic                      i_m_ready,
    input  logic [LGD_OUT_DATA_W-1:0] i_m_data
);

    logic                  occ;
    logic                  chg;
    logic [LGD_SITE_W-1:0] nbr;

    assign occ = i_m_data[LGD_O_OCC_BIT];
    assign chg = i_m_data[LGD_O_CHG_BIT];
    assign nbr = i_m_data[LGD_O_NBR_LSB +: LGD_SITE_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && !i_m_ready |=> i_m_valid && $stable(i_m_data))
        else $error("result item changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_valid)
        else $error("result valid right after reset");

    a_steady_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && occ && !chg |-> nbr == '0)
        else $error("neighbour reported for an occupied site that held");

    a_decay_nbr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && chg && !occ |-> nbr == '0)
        else $error("neighbour reported for a decayed site");

endmodule

bind lattice_growth_decay_update_top lgd_monitor u_monitor (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_valid (o_m_axis_tvalid),
    .i_m_ready (i_m_axis_tready),
    .i_m_data  (o_m_axis_tdata)
);
